[design/acia_serial_port_model_core_assert.svh]
// Assertion helpers used by the serial port engine.
`ifndef ACIA_SERIAL_PORT_MODEL_CORE_ASSERT_SVH
`define ACIA_SERIAL_PORT_MODEL_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACIA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/acia_pkg.sv]
`timescale 1ns / 1ps

package acia_pkg;

    // Operation codes
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Register select codes
    localparam logic REG_SEL_CTRL = 1'b0;
    localparam logic REG_SEL_DATA = 1'b1;

    // Status bit positions
    localparam int ST_RXFULL_BIT  = 0;
    localparam int ST_TXEMPTY_BIT = 1;
    localparam int ST_IRQ_BIT     = 7;
    localparam logic [7:0] STATUS_RESET = 8'h02;

    // Control decode
    localparam logic [7:0] CTRL_TXIRQ_MASK = 8'h60;
    localparam logic [7:0] CTRL_TXIRQ_EN   = 8'h20;
    localparam logic [7:0] CTRL_RXIRQ_EN   = 8'h80;
    localparam logic [7:0] CTRL_MRESET     = 8'h03;

    // Counter and interval
    localparam int CFG_W   = 16;
    localparam int COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [CFG_W-1:0]   INTERVAL_RESET = 16'd16;

    typedef struct packed {
        logic [1:0] func;
        logic       reg_select;
        logic [7:0] write_byte;
        logic [7:0] tick_count;
        logic       rx_offered;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       irq_n;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_taken;
    } t_out_item;

    // Handshake between the input register and the engine
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_in_stage;

endpackage

[design/acia_if.sv]
`timescale 1ns / 1ps

// Operation channel into the serial port
interface acia_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic       reg_select;
    logic [7:0] write_byte;
    logic [7:0] tick_count;
    logic       rx_offered;
    logic [7:0] rx_byte;

    modport source (output valid, func, reg_select, write_byte, tick_count, rx_offered,
                    rx_byte, input ready);
    modport sink   (input valid, func, reg_select, write_byte, tick_count, rx_offered,
                    rx_byte, output ready);
endinterface

// Result channel out of the serial port
interface acia_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       irq_n;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_taken;

    modport source (output valid, read_byte, irq_n, tx_valid, tx_byte, rx_taken,
                    input ready);
    modport sink   (input valid, read_byte, irq_n, tx_valid, tx_byte, rx_taken,
                    output ready);
endinterface

[design/acia_in_reg.sv]
`timescale 1ns / 1ps

module acia_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  acia_pkg::t_in_item  i_item,
    output logic                o_ready,
    output acia_pkg::t_in_stage o_stage,
    input  logic                i_take
);
    import acia_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // Free when empty or when the engine consumes the held transaction
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

[design/acia_engine.sv]
`timescale 1ns / 1ps
`include "acia_serial_port_model_core_assert.svh"

module acia_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [acia_pkg::CFG_W-1:0] i_cfg_data,
    input  acia_pkg::t_in_stage        i_stage,
    output logic                       o_take,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output acia_pkg::t_out_item        o_out_item
);
    import acia_pkg::*;

    // Architectural state
    logic [CFG_W-1:0]   r_interval;
    logic [7:0]         r_ctrl;
    logic [7:0]         r_status;
    logic [7:0]         r_rx_data;
    logic [7:0]         r_tx_data;
    logic [COUNT_W-1:0] r_count;

    logic [7:0]         n_ctrl;
    logic [7:0]         n_status;
    logic [7:0]         n_rx_data;
    logic [7:0]         n_tx_data;
    logic [COUNT_W-1:0] n_count;

    // Result register
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic               w_out_free;
    logic [COUNT_W:0]   w_sum;
    logic [COUNT_W-1:0] w_sat;
    logic               w_xfer;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_take     = i_stage.valid && w_out_free;

    // Saturating counter add and interval compare
    assign w_sum  = {1'b0, r_count} + {{(COUNT_W + 1 - 8){1'b0}}, i_stage.item.tick_count};
    assign w_sat  = w_sum[COUNT_W] ? COUNT_MAX : w_sum[COUNT_W-1:0];
    assign w_xfer = w_sat >= {{(COUNT_W - CFG_W){1'b0}}, r_interval};

    // One transaction of register update
    always_comb begin
        n_ctrl    = r_ctrl;
        n_status  = r_status;
        n_rx_data = r_rx_data;
        n_tx_data = r_tx_data;
        n_count   = r_count;
        n_out     = '0;

        case (i_stage.item.func)
            FUNC_READ: begin
                if (i_stage.item.reg_select == REG_SEL_CTRL) begin
                    n_out.read_byte = r_status;
                end else begin
                    n_status[ST_RXFULL_BIT] = 1'b0;
                    n_status[ST_IRQ_BIT]    = 1'b0;
                    n_out.read_byte         = r_rx_data;
                end
            end
            FUNC_WRITE: begin
                if (i_stage.item.reg_select == REG_SEL_CTRL) begin
                    n_ctrl = i_stage.item.write_byte;
                    if ((i_stage.item.write_byte & CTRL_MRESET) == CTRL_MRESET) begin
                        n_ctrl   = '0;
                        n_status = STATUS_RESET;
                        n_count  = '0;
                    end
                end else begin
                    n_tx_data                = i_stage.item.write_byte;
                    n_status[ST_TXEMPTY_BIT] = 1'b0;
                    n_status[ST_IRQ_BIT]     = 1'b0;
                end
            end
            FUNC_TICK: begin
                // Raise the interrupt on an enabled condition
                if (!r_status[ST_IRQ_BIT]) begin
                    if ((r_status[ST_TXEMPTY_BIT]
                            && (r_ctrl & CTRL_TXIRQ_MASK) == CTRL_TXIRQ_EN)
                        || (r_status[ST_RXFULL_BIT]
                            && (r_ctrl & CTRL_RXIRQ_EN) == CTRL_RXIRQ_EN)) begin
                        n_status[ST_IRQ_BIT] = 1'b1;
                    end
                end
                n_count = w_sat;
                // Character transfer at the interval
                if (w_xfer) begin
                    n_count = '0;
                    if (!r_status[ST_RXFULL_BIT] && i_stage.item.rx_offered) begin
                        n_rx_data               = i_stage.item.rx_byte;
                        n_status[ST_RXFULL_BIT] = 1'b1;
                        n_out.rx_taken          = 1'b1;
                    end
                    if (!r_status[ST_TXEMPTY_BIT]) begin
                        n_out.tx_valid           = 1'b1;
                        n_out.tx_byte            = r_tx_data;
                        n_status[ST_TXEMPTY_BIT] = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        n_out.irq_n = !n_status[ST_IRQ_BIT];
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RESET;
            r_ctrl     <= '0;
            r_status   <= STATUS_RESET;
            r_rx_data  <= '0;
            r_tx_data  <= '0;
            r_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_interval <= i_cfg_data;
            end
            if (o_take) begin
                r_ctrl    <= n_ctrl;
                r_status  <= n_status;
                r_rx_data <= n_rx_data;
                r_tx_data <= n_tx_data;
                r_count   <= n_count;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Checks
    `ACIA_ASSERT_NEXT(a_tx_sets_empty, i_clk, i_rst_n, o_take && n_out.tx_valid, r_status[ST_TXEMPTY_BIT], "transmit did not set transmit-empty")
    `ACIA_ASSERT_NEXT(a_rx_latched, i_clk, i_rst_n, o_take && n_out.rx_taken, r_status[ST_RXFULL_BIT] && r_rx_data == $past(i_stage.item.rx_byte), "received byte not latched")
    `ACIA_ASSERT_NEXT(a_irq_matches, i_clk, i_rst_n, o_take, r_out.irq_n == !r_status[ST_IRQ_BIT], "irq_n disagrees with status")
    `ACIA_ASSERT_NOW(a_take_needs_room, i_clk, i_rst_n, o_take, !r_out_valid || i_out_ready, "result register overwritten")

endmodule

[design/acia_serial_port_model_core.sv]
`timescale 1ns / 1ps
// A transaction accepted on the operation channel is registered in the input register, is
// processed by the engine into the result register, and is presented on the result channel.
// Throughput: one transaction per cycle while the result channel is ready; the single state
// update between the input register and the result register sets that figure.
// Reset (i_rst_n low at a clock edge, synchronous): both stages empty, control 0,
// status transmit-empty, data bytes and counter 0, tick interval 16.
module acia_serial_port_model_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [acia_pkg::CFG_W-1:0] i_cfg_data,
    acia_in_if.sink                    i_in,
    acia_out_if.source                 o_out
);
    import acia_pkg::*;

    t_in_item  w_in_item;
    t_in_stage w_stage;
    logic      w_take;
    t_out_item w_out_item;
    logic      w_out_valid;

    assign w_in_item.func       = i_in.func;
    assign w_in_item.reg_select = i_in.reg_select;
    assign w_in_item.write_byte = i_in.write_byte;
    assign w_in_item.tick_count = i_in.tick_count;
    assign w_in_item.rx_offered = i_in.rx_offered;
    assign w_in_item.rx_byte    = i_in.rx_byte;

    acia_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (w_in_item),
        .o_ready (i_in.ready),
        .o_stage (w_stage),
        .i_take  (w_take)
    );

    acia_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_stage     (w_stage),
        .o_take      (w_take),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_out_item  (w_out_item)
    );

    assign o_out.valid     = w_out_valid;
    assign o_out.read_byte = w_out_item.read_byte;
    assign o_out.irq_n     = w_out_item.irq_n;
    assign o_out.tx_valid  = w_out_item.tx_valid;
    assign o_out.tx_byte   = w_out_item.tx_byte;
    assign o_out.rx_taken  = w_out_item.rx_taken;

endmodule

[test/tb_acia_serial_port_model_core.sv]
`timescale 1ns / 1ps

module tb_acia_serial_port_model_core;
    import acia_pkg::*;

    // func value with no operation behind it; the block must return an idle result
    localparam logic [1:0] FUNC_NOP = 2'd3;
    localparam int MAX_PRINTED = 40;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    acia_in_if  op_ch ();
    acia_out_if res_ch ();

    acia_serial_port_model_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (op_ch),
        .o_out      (res_ch)
    );

    // Clock: 8 ns period
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------
    // Shadow ACIA state
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]   sh_interval;
    logic [7:0]         sh_ctrl;
    logic [7:0]         sh_status;
    logic [7:0]         sh_rx_data;
    logic [7:0]         sh_tx_data;
    logic [COUNT_W-1:0] sh_count;

    function automatic t_out_item predict_acia_step(input t_in_item op);
        t_out_item     res;
        logic [COUNT_W:0] sum;
        logic          tx_irq;
        logic          rx_irq;
        res = '0;
        case (op.func)
            FUNC_READ: begin
                if (op.reg_select == REG_SEL_CTRL) begin
                    res.read_byte = sh_status;
                end else begin
                    sh_status[ST_RXFULL_BIT] = 1'b0;
                    sh_status[ST_IRQ_BIT]    = 1'b0;
                    res.read_byte = sh_rx_data;
                end
            end
            FUNC_WRITE: begin
                if (op.reg_select == REG_SEL_CTRL) begin
                    sh_ctrl = op.write_byte;
                    // master reset leaves the data bytes and the interval alone
                    if ((sh_ctrl & CTRL_MRESET) == CTRL_MRESET) begin
                        sh_ctrl   = '0;
                        sh_status = STATUS_RESET;
                        sh_count  = '0;
                    end
                end else begin
                    sh_tx_data = op.write_byte;
                    sh_status[ST_IRQ_BIT]     = 1'b0;
                    sh_status[ST_TXEMPTY_BIT] = 1'b0;
                end
            end
            FUNC_TICK: begin
                // interrupt is evaluated before the transfer
                if (!sh_status[ST_IRQ_BIT]) begin
                    tx_irq = sh_status[ST_TXEMPTY_BIT] &&
                             ((sh_ctrl & CTRL_TXIRQ_MASK) == CTRL_TXIRQ_EN);
                    rx_irq = sh_status[ST_RXFULL_BIT] &&
                             ((sh_ctrl & CTRL_RXIRQ_EN) == CTRL_RXIRQ_EN);
                    if (tx_irq || rx_irq)
                        sh_status[ST_IRQ_BIT] = 1'b1;
                end
                sum = {1'b0, sh_count} + {{(COUNT_W + 1 - 8){1'b0}}, op.tick_count};
                sh_count = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_W-1:0];
                if (sh_count >= {1'b0, sh_interval}) begin
                    sh_count = '0;
                    if (!sh_status[ST_RXFULL_BIT] && op.rx_offered) begin
                        sh_rx_data = op.rx_byte;
                        sh_status[ST_RXFULL_BIT] = 1'b1;
                        res.rx_taken = 1'b1;
                    end
                    if (!sh_status[ST_TXEMPTY_BIT]) begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = sh_tx_data;
                        sh_status[ST_TXEMPTY_BIT] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.irq_n = ~sh_status[ST_IRQ_BIT];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    t_in_item  op_queue[$];
    t_out_item pending_results[$];
    int        ops_queued;
    int        ops_sent;
    int        results_seen;
    int        mismatches;
    int        tx_seen;
    int        rx_seen;
    int        irq_seen;
    int        cfg_writes;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTED)
            $display("%0t MISMATCH %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of transactions with random gaps
    // ------------------------------------------------------------------
    t_in_item held_op;
    t_in_item next_op;
    int       burst_left;
    int       gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            op_ch.valid <= 1'b0;
            burst_left = $urandom_range(1, 24);
            gap_left   = 0;
        end else begin
            if (op_ch.valid && op_ch.ready) begin
                pending_results.push_back(predict_acia_step(held_op));
                ops_sent++;
            end
            if (!op_ch.valid || op_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    op_ch.valid <= 1'b0;
                end else if (op_queue.size() > 0) begin
                    next_op = op_queue.pop_front();
                    held_op = next_op;
                    op_ch.func       <= next_op.func;
                    op_ch.reg_select <= next_op.reg_select;
                    op_ch.write_byte <= next_op.write_byte;
                    op_ch.tick_count <= next_op.tick_count;
                    op_ch.rx_offered <= next_op.rx_offered;
                    op_ch.rx_byte    <= next_op.rx_byte;
                    op_ch.valid      <= 1'b1;
                    if (burst_left <= 1) begin
                        // occasional long run with no idle cycles
                        burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    op_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: result checking with a rotating stall pattern
    // ------------------------------------------------------------------
    logic [15:0] stall_pat;
    int          stall_left;
    t_out_item   want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_pat  = 16'hffff;
            stall_left = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing expected", res_ch.read_byte, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (res_ch.read_byte !== want.read_byte)
                        report_mismatch("read_byte", res_ch.read_byte, want.read_byte);
                    if (res_ch.irq_n !== want.irq_n)
                        report_mismatch("irq_n", res_ch.irq_n, want.irq_n);
                    if (res_ch.tx_valid !== want.tx_valid)
                        report_mismatch("tx_valid", res_ch.tx_valid, want.tx_valid);
                    if (res_ch.tx_byte !== want.tx_byte)
                        report_mismatch("tx_byte", res_ch.tx_byte, want.tx_byte);
                    if (res_ch.rx_taken !== want.rx_taken)
                        report_mismatch("rx_taken", res_ch.rx_taken, want.rx_taken);
                    tx_seen  += want.tx_valid;
                    rx_seen  += want.rx_taken;
                    irq_seen += !want.irq_n;
                end
            end
            // new stall mode every so often: none, random, or light
            if (stall_left == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pat = 16'hffff;
                    1: stall_pat = 16'($urandom_range(0, 16'hffff));
                    default: stall_pat = 16'($urandom_range(0, 16'hffff)
                                             | $urandom_range(0, 16'hffff));
                endcase
                stall_left = $urandom_range(16, 96);
            end else begin
                stall_left--;
                stall_pat = {stall_pat[0], stall_pat[15:1]};
            end
            res_ch.ready <= stall_pat[0];
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic t_in_item make_op(input logic [1:0] func, input logic sel,
                                         input logic [7:0] wbyte, input logic [7:0] ticks,
                                         input logic offered, input logic [7:0] rbyte);
        t_in_item op;
        op.func       = func;
        op.reg_select = sel;
        op.write_byte = wbyte;
        op.tick_count = ticks;
        op.rx_offered = offered;
        op.rx_byte    = rbyte;
        return op;
    endfunction

    // Random transaction; tick_heavy favors long full-count ticks for big intervals
    function automatic t_in_item random_op(input bit tick_heavy);
        t_in_item op;
        int       pick;
        op.func       = FUNC_NOP;
        op.reg_select = 1'($urandom_range(0, 1));
        op.write_byte = 8'($urandom_range(0, 255));
        op.tick_count = 8'($urandom_range(0, 255));
        op.rx_offered = ($urandom_range(0, 9) < 7);
        op.rx_byte    = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (tick_heavy) begin
            if (pick < 85) begin
                op.func = FUNC_TICK;
                op.tick_count = ($urandom_range(0, 4) == 0) ? op.tick_count : 8'hff;
            end else if (pick < 92) begin
                op.func = FUNC_READ;
            end else if (pick < 97) begin
                op.func = FUNC_WRITE;
                op.reg_select = REG_SEL_DATA;
            end
        end else if (pick < 40) begin
            op.func = FUNC_TICK;
            case ($urandom_range(0, 3))
                0: op.tick_count = 8'hff;
                1: op.tick_count = 8'($urandom_range(0, 8));
                2: op.tick_count = '0;
                default: ;
            endcase
        end else if (pick < 62) begin
            op.func = FUNC_READ;
        end else if (pick < 78) begin
            op.func = FUNC_WRITE;
            op.reg_select = REG_SEL_DATA;
        end else if (pick < 93) begin
            op.func = FUNC_WRITE;
            op.reg_select = REG_SEL_CTRL;
            // keep master reset rare on plain control writes
            if ((op.write_byte & CTRL_MRESET) == CTRL_MRESET && $urandom_range(0, 9) != 0)
                op.write_byte[0] = 1'b0;
        end else if (pick < 96) begin
            op.func = FUNC_WRITE;
            op.reg_select = REG_SEL_CTRL;
            op.write_byte = op.write_byte | CTRL_MRESET;
        end
        return op;
    endfunction

    task automatic wait_idle();
        while (results_seen != ops_queued)
            @(posedge i_clk);
        // allow the pipeline to drain past the last result
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sh_interval = value;
        cfg_writes++;
    endtask

    task automatic queue_op(input t_in_item op);
        op_queue.push_back(op);
        ops_queued++;
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] interval, input int count,
                                    input bit tick_heavy);
        wait_idle();
        write_interval(interval);
        repeat (count) queue_op(random_op(tick_heavy));
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        op_ch.valid    = 1'b0;
        op_ch.func     = FUNC_READ;
        op_ch.reg_select = REG_SEL_CTRL;
        op_ch.write_byte = '0;
        op_ch.tick_count = '0;
        op_ch.rx_offered = 1'b0;
        op_ch.rx_byte    = '0;
        res_ch.ready   = 1'b0;
        sh_interval    = INTERVAL_RESET;
        sh_ctrl        = '0;
        sh_status      = STATUS_RESET;
        sh_rx_data     = '0;
        sh_tx_data     = '0;
        sh_count       = '0;
        ops_queued     = 0;
        ops_sent       = 0;
        results_seen   = 0;
        mismatches     = 0;
        tx_seen        = 0;
        rx_seen        = 0;
        irq_seen       = 0;
        cfg_writes     = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed sequence at the default interval
        write_interval(INTERVAL_RESET);
        queue_op(make_op(FUNC_READ,  REG_SEL_CTRL, 8'h00, 8'h00, 1'b0, 8'h00)); // reset status
        queue_op(make_op(FUNC_READ,  REG_SEL_DATA, 8'hff, 8'hff, 1'b1, 8'hff)); // empty data
        queue_op(make_op(FUNC_TICK,  REG_SEL_CTRL, 8'h00, 8'h00, 1'b1, 8'h11)); // zero count
        queue_op(make_op(FUNC_TICK,  REG_SEL_DATA, 8'h00, 8'hff, 1'b1, 8'hff)); // rx taken
        queue_op(make_op(FUNC_TICK,  REG_SEL_CTRL, 8'h00, 8'hff, 1'b1, 8'h00)); // rx full
        queue_op(make_op(FUNC_WRITE, REG_SEL_CTRL, 8'ha0, 8'h00, 1'b0, 8'h00)); // both irqs
        queue_op(make_op(FUNC_TICK,  REG_SEL_CTRL, 8'h00, 8'h00, 1'b0, 8'h00)); // irq rises
        queue_op(make_op(FUNC_READ,  REG_SEL_CTRL, 8'h00, 8'h00, 1'b0, 8'h00)); // status 0x83
        queue_op(make_op(FUNC_READ,  REG_SEL_DATA, 8'h00, 8'h00, 1'b0, 8'h00)); // clears irq
        queue_op(make_op(FUNC_WRITE, REG_SEL_DATA, 8'h00, 8'h00, 1'b0, 8'h00));
        queue_op(make_op(FUNC_WRITE, REG_SEL_DATA, 8'hff, 8'h00, 1'b0, 8'h00)); // overwrite
        queue_op(make_op(FUNC_TICK,  REG_SEL_CTRL, 8'h00, 8'hff, 1'b0, 8'h00)); // tx 0xff
        queue_op(make_op(FUNC_TICK,  REG_SEL_CTRL, 8'h00, 8'h10, 1'b0, 8'h00));
        queue_op(make_op(FUNC_WRITE, REG_SEL_CTRL, 8'hff, 8'h00, 1'b0, 8'h00)); // master reset
        queue_op(make_op(FUNC_READ,  REG_SEL_CTRL, 8'h00, 8'h00, 1'b0, 8'h00));
        queue_op(make_op(FUNC_NOP,   REG_SEL_DATA, 8'hff, 8'hff, 1'b1, 8'hff));
        queue_op(make_op(FUNC_WRITE, REG_SEL_CTRL, 8'h80, 8'h00, 1'b0, 8'h00)); // rx irq only
        queue_op(make_op(FUNC_TICK,  REG_SEL_CTRL, 8'h00, 8'hff, 1'b1, 8'h5a));
        queue_op(make_op(FUNC_TICK,  REG_SEL_CTRL, 8'h00, 8'h00, 1'b0, 8'h00));
        queue_op(make_op(FUNC_WRITE, REG_SEL_DATA, 8'h3c, 8'h00, 1'b0, 8'h00)); // clears irq
        queue_op(make_op(FUNC_TICK,  REG_SEL_CTRL, 8'h00, 8'hff, 1'b1, 8'ha5)); // tx 0x3c
        queue_op(make_op(FUNC_READ,  REG_SEL_DATA, 8'h00, 8'h00, 1'b0, 8'h00));
        queue_op(make_op(FUNC_WRITE, REG_SEL_CTRL, 8'h03, 8'h00, 1'b0, 8'h00)); // master reset
        queue_op(make_op(FUNC_NOP,   REG_SEL_CTRL, 8'h00, 8'h00, 1'b0, 8'h00));

        // Random phases over a spread of intervals, extremes included
        run_random_phase(16'd0, 100, 1'b0);
        run_random_phase(16'd1, 100, 1'b0);
        run_random_phase(16'hffff, 360, 1'b1);
        run_random_phase(16'd3, 100, 1'b0);
        run_random_phase(16'd255, 100, 1'b0);
        run_random_phase(CFG_W'($urandom_range(2, 600)), 100, 1'b0);
        run_random_phase(16'd7, 70, 1'b0);

        wait_idle();
        repeat (10) @(posedge i_clk);
        while (pending_results.size() > 0) begin
            want = pending_results.pop_front();
            report_mismatch("expected result never arrived", 0, want.read_byte);
        end

        $display("Run covered %0d transactions over %0d interval settings", ops_sent, cfg_writes);
        $display("Transfers: %0d transmitted, %0d received, %0d results with irq asserted",
                 tx_seen, rx_seen, irq_seen);
        if (mismatches == 0) begin
            $display("tb_acia_serial_port_model_core passed");
        end else begin
            $display("tb_acia_serial_port_model_core failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("Timeout with %0d of %0d results seen", results_seen, ops_queued);
        $display("tb_acia_serial_port_model_core failed");
        $finish;
    end

endmodule
